// File: rtl/sme_pkg.sv
// Package for the stack machine executor: widths, opcodes, status codes and
// the structs passed between the issue and execute stages.
// No dependencies.
`timescale 1ns / 1ps

package sme_pkg;

  localparam int STACK_ENTRIES = 64;
  localparam int MEM_BYTES     = 8 * 1024;
  localparam int CELL_BITS     = 32;

  localparam int OP_W    = 4;
  localparam int NCELL_W = 32;
  localparam int ICHAR_W = 9;
  localparam int PTR_W   = 32;
  localparam int OCHAR_W = 8;
  localparam int STAT_W  = 2;

  localparam int IN_W       = OP_W + NCELL_W + ICHAR_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = PTR_W + OCHAR_W + 1 + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_W;

  localparam int SIDX_W     = $clog2(STACK_ENTRIES);
  localparam int SDEP_W     = $clog2(STACK_ENTRIES + 1);
  localparam int SADDR_W    = SIDX_W + 1;
  localparam int SRAM_DEPTH = 2 * (1 << SIDX_W);
  localparam int BADDR_W    = $clog2(MEM_BYTES);

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [SDEP_W-1:0]    sdep_t;
  typedef logic [SADDR_W-1:0]   saddr_t;
  typedef logic [BADDR_W-1:0]   baddr_t;
  typedef logic [OP_W-1:0]      op_t;
  typedef logic [STAT_W-1:0]    stat_t;

  localparam sdep_t DEP_ONE   = SDEP_W'(1);
  localparam sdep_t DEP_TWO   = SDEP_W'(2);
  localparam sdep_t DEP_THREE = SDEP_W'(3);
  localparam sdep_t DEP_FULL  = SDEP_W'(STACK_ENTRIES);

  localparam logic SEL_DATA   = 1'b0;
  localparam logic SEL_RETURN = 1'b1;

  localparam op_t OP_HALT   = 4'd0;
  localparam op_t OP_DUP    = 4'd1;
  localparam op_t OP_SWAP   = 4'd2;
  localparam op_t OP_DROP   = 4'd3;
  localparam op_t OP_TOR    = 4'd4;
  localparam op_t OP_FROMR  = 4'd5;
  localparam op_t OP_ADD    = 4'd6;
  localparam op_t OP_NAND   = 4'd7;
  localparam op_t OP_QUERY  = 4'd8;
  localparam op_t OP_DOT    = 4'd9;
  localparam op_t OP_SKIP   = 4'd10;
  localparam op_t OP_EXIT   = 4'd11;
  localparam op_t OP_BRANCH = 4'd12;
  localparam op_t OP_LIT    = 4'd13;
  localparam op_t OP_CSTORE = 4'd14;
  localparam op_t OP_CFETCH = 4'd15;

  localparam stat_t ST_RUN   = 2'd0;
  localparam stat_t ST_HALT  = 2'd1;
  localparam stat_t ST_FAULT = 2'd2;

  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic                 run;
    stat_t                status;
    logic [NCELL_W-1:0]   next_cell;
    logic [ICHAR_W-1:0]   input_char;
    saddr_t               wr_addr;
    logic                 hit_a;
    logic                 hit_b;
    cell_t                fwd_data;
  } issue_t;

  typedef struct packed {
    logic   en;
    saddr_t addr;
    cell_t  data;
  } wr_t;

  typedef struct packed {
    logic   we;
    logic   re;
    baddr_t addr;
    logic [7:0] wdata;
  } bm_req_t;

endpackage

// File: rtl/sme_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: rtl/sme_ctrl.sv
// Issue stage: stack depth tracking, fault and halt decisions, stack RAM
// read addressing and write-forwarding capture. Uses sme_pkg.
`timescale 1ns / 1ps

module sme_ctrl import sme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  op_t                command,
  input  logic [NCELL_W-1:0] next_cell,
  input  logic [ICHAR_W-1:0] input_char,
  input  logic               commit,
  input  wr_t                wr,
  output logic               rd_en,
  output saddr_t             rd_addr_a,
  output saddr_t             rd_addr_b,
  output issue_t             iss
);

  sdep_t  d;
  sdep_t  rd;
  logic   halted;
  sdep_t  d_next;
  sdep_t  rd_next;
  logic   fault;
  saddr_t wr_addr;
  logic   accept;

  function automatic saddr_t dslot(input sdep_t x);
    return {SEL_DATA, x[SIDX_W-1:0]};
  endfunction

  function automatic saddr_t rslot(input sdep_t x);
    return {SEL_RETURN, x[SIDX_W-1:0]};
  endfunction

  assign s_tready = !iss.valid || commit;
  assign accept   = s_tvalid && s_tready;
  assign rd_en    = accept;

  assign rd_addr_a = dslot(d - DEP_TWO);
  assign rd_addr_b = (command == OP_CSTORE) ? dslot(d - DEP_THREE) : rslot(rd - DEP_ONE);

  always_comb begin
    fault   = 1'b0;
    d_next  = d;
    rd_next = rd;
    wr_addr = dslot(d - DEP_ONE);
    case (command)
      OP_HALT: begin
      end
      OP_DUP: begin
        fault  = (d < DEP_ONE) || (d == DEP_FULL);
        d_next = d + DEP_ONE;
      end
      OP_SWAP: begin
        fault   = d < DEP_TWO;
        wr_addr = dslot(d - DEP_TWO);
      end
      OP_TOR: begin
        fault   = (d < DEP_ONE) || (rd == DEP_FULL);
        d_next  = d - DEP_ONE;
        rd_next = rd + DEP_ONE;
        wr_addr = rslot(rd);
      end
      OP_FROMR: begin
        fault   = (rd < DEP_ONE) || (d == DEP_FULL);
        d_next  = d + DEP_ONE;
        rd_next = rd - DEP_ONE;
      end
      OP_ADD, OP_NAND: begin
        fault  = d < DEP_TWO;
        d_next = d - DEP_ONE;
      end
      OP_QUERY, OP_LIT: begin
        fault  = d == DEP_FULL;
        d_next = d + DEP_ONE;
      end
      OP_DROP, OP_DOT, OP_SKIP, OP_BRANCH: begin
        fault  = d < DEP_ONE;
        d_next = d - DEP_ONE;
      end
      OP_EXIT: begin
        fault   = rd < DEP_ONE;
        rd_next = rd - DEP_ONE;
      end
      OP_CSTORE: begin
        fault  = d < DEP_TWO;
        d_next = d - DEP_TWO;
      end
      OP_CFETCH: begin
        fault = d < DEP_ONE;
      end
      default: begin
        fault = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d         <= '0;
      rd        <= '0;
      halted    <= 1'b0;
      iss.valid <= 1'b0;
    end else begin
      if (accept) begin
        iss.valid      <= 1'b1;
        iss.op         <= command;
        iss.run        <= !halted && !fault && (command != OP_HALT);
        iss.status     <= (halted || command == OP_HALT) ? ST_HALT :
                          fault ? ST_FAULT : ST_RUN;
        iss.next_cell  <= next_cell;
        iss.input_char <= input_char;
        iss.wr_addr    <= wr_addr;
        iss.hit_a      <= wr.en && (wr.addr == rd_addr_a);
        iss.hit_b      <= wr.en && (wr.addr == rd_addr_b);
        iss.fwd_data   <= wr.data;
        if (!halted && !fault) begin
          d  <= d_next;
          rd <= rd_next;
          if (command == OP_HALT) begin
            halted <= 1'b1;
          end
        end
      end else if (commit) begin
        iss.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (d <= DEP_FULL) && (rd <= DEP_FULL))
    else $error("stack depth beyond capacity");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag cleared without reset");

  a_run_status: assert property (@(posedge clk) disable iff (rst)
    (iss.valid && iss.run) |-> (iss.status == ST_RUN))
    else $error("executing item carries a non-running status");
`endif

endmodule

// File: rtl/sme_exec.sv
// Execute stage: top-of-stack register, instruction pointer, byte memory
// access and the output register. Uses sme_pkg.
`timescale 1ns / 1ps

module sme_exec import sme_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  issue_t                 iss,
  input  cell_t                  srd_a,
  input  cell_t                  srd_b,
  output logic                   commit,
  output wr_t                    wr,
  output bm_req_t                bm,
  input  logic [7:0]             bm_rdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cell_t             t_reg;
  logic              pend;
  ptr_t              ptr;
  cell_t             t_eff;
  cell_t             a_val;
  cell_t             b_val;
  cell_t             t_new;
  ptr_t              base;
  ptr_t              ptr_next;
  logic              emit;
  logic [OCHAR_W-1:0] ochar;
  ptr_t              out_ptr;
  logic              out_emit;
  logic [OCHAR_W-1:0] out_ochar;
  stat_t             out_status;

  assign t_eff = pend ? cell_t'(bm_rdata) : t_reg;
  assign a_val = iss.hit_a ? iss.fwd_data : srd_a;
  assign b_val = iss.hit_b ? iss.fwd_data : srd_b;

  assign commit = iss.valid && (!m_tvalid || m_tready);

  always_comb begin
    t_new = t_eff;
    base  = ptr;
    emit  = 1'b0;
    ochar = '0;
    if (iss.run) begin
      case (iss.op)
        OP_SWAP, OP_DROP, OP_TOR, OP_SKIP: t_new = a_val;
        OP_FROMR, OP_CSTORE:              t_new = b_val;
        OP_ADD:                           t_new = t_eff + a_val;
        OP_NAND:                          t_new = ~(t_eff & a_val);
        OP_QUERY:                         t_new = cell_t'($signed(iss.input_char));
        OP_LIT:                           t_new = cell_t'($signed(iss.next_cell));
        OP_DOT: begin
          t_new = a_val;
          emit  = 1'b1;
          ochar = t_eff[OCHAR_W-1:0];
        end
        OP_EXIT: begin
          base = PTR_W'(b_val);
        end
        OP_BRANCH: begin
          t_new = a_val;
          base  = ptr + PTR_W'(t_eff);
        end
        default: begin
          t_new = t_eff;
        end
      endcase
    end
  end

  assign ptr_next = base + (((iss.op == OP_LIT) ||
                             ((iss.op == OP_SKIP) && (t_eff != '0))) ? PTR_W'(2) : PTR_W'(1));

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = iss.wr_addr;
    wr.data = t_eff;
    case (iss.op)
      OP_DUP, OP_SWAP, OP_TOR, OP_FROMR, OP_QUERY, OP_LIT: wr.en = commit && iss.run;
      default: wr.en = 1'b0;
    endcase
  end

  always_comb begin
    bm.we    = commit && iss.run && (iss.op == OP_CSTORE);
    bm.re    = commit && iss.run && (iss.op == OP_CFETCH);
    bm.addr  = t_eff[BADDR_W-1:0];
    bm.wdata = a_val[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      ptr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (commit) begin
        pend     <= bm.re;
        m_tvalid <= 1'b1;
        if (iss.run) begin
          ptr <= ptr_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      t_reg      <= t_new;
      out_ptr    <= iss.run ? ptr_next : ptr;
      out_emit   <= emit;
      out_ochar  <= ochar;
      out_status <= iss.status;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_emit, out_ochar, out_ptr};

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !commit)
    else $error("execute stage committed over a held result");
`endif

endmodule

// File: rtl/stack_machine_executor.sv
// Top level of the stack machine executor: issue stage, execute stage,
// stack RAM and byte RAM. Uses sme_pkg, sme_ram, sme_ctrl, sme_exec.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: command, next_cell, input_char
//  m_*       out  m_tvalid/m_tready  m_tdata: next_pointer, out_char,
//                                    out_valid, status
//
// One instruction per cycle sustained while results are taken; each
// instruction passes the issue register, then its result the output
// register. The execute stage sets the rate, working on the top-of-stack
// register and the two forwarded stack RAM read ports, issued at transfer in.
// Reset clears the depths, instruction pointer, halted flag and valids;
// stack and byte contents are not cleared and no clearing pass is run.
// While a result is held, at most one more instruction is taken, then
// input stalls until the result is transferred.
`timescale 1ns / 1ps

module stack_machine_executor import sme_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command [3:0], next_cell [35:4], input_char [44:36], zero padding above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // next_pointer [31:0], out_char [39:32], out_valid [40], status [42:41],
  // zero padding above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  issue_t     iss;
  wr_t        wr;
  bm_req_t    bm;
  logic       commit;
  logic       rd_en;
  saddr_t     rd_addr_a;
  saddr_t     rd_addr_b;
  cell_t      srd_a;
  cell_t      srd_b;
  logic [7:0] bm_rdata;

  sme_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .command    (s_tdata[OP_W-1:0]),
    .next_cell  (s_tdata[OP_W+NCELL_W-1:OP_W]),
    .input_char (s_tdata[IN_W-1:OP_W+NCELL_W]),
    .commit     (commit),
    .wr         (wr),
    .rd_en      (rd_en),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .iss        (iss)
  );

  sme_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (SRAM_DEPTH)
  ) u_stack_ram (
    .clk       (clk),
    .wr_en     (wr.en),
    .wr_addr   (wr.addr),
    .wr_data   (wr.data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (srd_a),
    .rd_data_b (srd_b)
  );

  sme_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_byte_ram (
    .clk       (clk),
    .wr_en     (bm.we),
    .wr_addr   (bm.addr),
    .wr_data   (bm.wdata),
    .rd_en     (bm.re),
    .rd_addr_a (bm.addr),
    .rd_addr_b (bm.addr),
    .rd_data_a (bm_rdata),
    .rd_data_b ()
  );

  sme_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .iss      (iss),
    .srd_a    (srd_a),
    .srd_b    (srd_b),
    .commit   (commit),
    .wr       (wr),
    .bm       (bm),
    .bm_rdata (bm_rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: tb/tb_stack_machine_executor.sv
// Self-checking testbench for stack_machine_executor: streams opcodes in,
// predicts every step in a local model of both stacks and byte memory.
// Depends on sme_pkg and the stack_machine_executor RTL only.
`timescale 1ns / 1ps

module tb_stack_machine_executor import sme_pkg::*; ();

  localparam int GEN      = 0;
  localparam int CHK      = 1;
  localparam int HOLD_AT  = 120;
  localparam int HOLD_LEN = 400;
  localparam int LIMIT    = 4000;
  localparam int MAX_MSG  = 20;

  typedef struct packed {
    logic [ICHAR_W-1:0] ichar;
    logic [NCELL_W-1:0] ncell;
    op_t                cmd;
  } instr_t;

  typedef struct packed {
    stat_t             status;
    logic              ovalid;
    logic [OCHAR_W-1:0] ochar;
    ptr_t              ptr;
  } step_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // two copies of the machine state: one runs ahead with the generator,
  // one follows the accepted transfers
  cell_t      dstk [2][STACK_ENTRIES];
  cell_t      rstk [2][STACK_ENTRIES];
  int         ddep [2];
  int         rdep [2];
  ptr_t       ipr  [2];
  logic       hlt  [2];
  logic [7:0] bmem [2][MEM_BYTES];
  bit         bwr  [2][MEM_BYTES];

  instr_t     instr_q[$];
  step_res_t  step_result_q[$];
  baddr_t     stored_lo[$];

  instr_t     drv_instr;
  int         gap_left;
  bit         drv_steady;
  int         stall_left;
  bit         mon_steady;
  logic       res_fire = 1'b0;
  step_res_t  res_got;
  step_res_t  want_res;
  int         hold_left;
  bit         hold_done;
  int         idle_cycles;

  int n_gen, n_in, n_out, n_fault, n_emit, n_halt, err_cnt;

  stack_machine_executor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // command, next_cell, input_char
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // next_pointer, out_char, out_valid, status
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_model(int m);
    ipr[m]  = '0;
    ddep[m] = 0;
    rdep[m] = 0;
    hlt[m]  = 1'b0;
    for (int i = 0; i < MEM_BYTES; i++) bwr[m][i] = 1'b0;
  endfunction

  function automatic step_res_t execute_op(int m, instr_t c);
    step_res_t r;
    int        d, dn, dd, rn, rd;
    cell_t     a, b;
    ptr_t      p, adv;
    r  = '0;
    d  = ddep[m];
    dn = 0;
    dd = 0;
    rn = 0;
    rd = 0;
    case (c.cmd)
      OP_DUP: begin
        dn = 1; dd = 1;
      end
      OP_SWAP:   dn = 2;
      OP_DROP, OP_DOT, OP_SKIP, OP_BRANCH: begin
        dn = 1; dd = -1;
      end
      OP_TOR: begin
        dn = 1; dd = -1; rd = 1;
      end
      OP_FROMR: begin
        dd = 1; rn = 1; rd = -1;
      end
      OP_ADD, OP_NAND: begin
        dn = 2; dd = -1;
      end
      OP_QUERY, OP_LIT: dd = 1;
      OP_EXIT: begin
        rn = 1; rd = -1;
      end
      OP_CSTORE: begin
        dn = 2; dd = -2;
      end
      OP_CFETCH: dn = 1;
      default: ;
    endcase
    r.ptr = ipr[m];
    if (hlt[m]) begin
      r.status = ST_HALT;
    end else if (d < dn || d + dd > STACK_ENTRIES ||
                 rdep[m] < rn || rdep[m] + rd > STACK_ENTRIES) begin
      r.status = ST_FAULT;
    end else if (c.cmd == OP_HALT) begin
      hlt[m]   = 1'b1;
      r.status = ST_HALT;
    end else begin
      a   = (d > 0) ? dstk[m][d-1] : '0;
      b   = (d > 1) ? dstk[m][d-2] : '0;
      p   = ipr[m];
      adv = 1;
      case (c.cmd)
        OP_DUP:    dstk[m][d] = a;
        OP_SWAP: begin
          dstk[m][d-1] = b;
          dstk[m][d-2] = a;
        end
        OP_TOR:    rstk[m][rdep[m]] = a;
        OP_FROMR:  dstk[m][d] = rstk[m][rdep[m]-1];
        OP_ADD:    dstk[m][d-2] = a + b;
        OP_NAND:   dstk[m][d-2] = ~(a & b);
        OP_QUERY:  dstk[m][d] = {{(CELL_BITS-ICHAR_W){c.ichar[ICHAR_W-1]}}, c.ichar};
        OP_DOT: begin
          r.ochar  = a[7:0];
          r.ovalid = 1'b1;
        end
        OP_SKIP:   if (a != '0) adv = 2;
        OP_EXIT:   p = rstk[m][rdep[m]-1];
        OP_BRANCH: p = p + a;
        OP_LIT: begin
          dstk[m][d] = c.ncell;
          adv = 2;
        end
        OP_CSTORE: begin
          bmem[m][baddr_t'(a)] = b[7:0];
          bwr[m][baddr_t'(a)]  = 1'b1;
        end
        OP_CFETCH: dstk[m][d-1] = cell_t'(bmem[m][baddr_t'(a)]);
        default: ;
      endcase
      ddep[m]  = d + dd;
      rdep[m]  = rdep[m] + rd;
      ipr[m]   = p + adv;
      r.ptr    = ipr[m];
      r.status = ST_RUN;
    end
    return r;
  endfunction

  function automatic int idle_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [NCELL_W-1:0] rnd_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r == 2) return 32'h8000_0000;
    if (r == 3) return 32'hFFFF_FFFF;
    if (r < 6)  return $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic logic [ICHAR_W-1:0] rnd_ichar();
    int v;
    v = $urandom_range(0, 256);
    return (v == 256) ? {ICHAR_W{1'b1}} : ICHAR_W'(v);
  endfunction

  function automatic op_t rnd_stack_op();
    case ($urandom_range(0, 7))
      0:       return OP_DUP;
      1:       return OP_SWAP;
      2:       return OP_DROP;
      3:       return OP_ADD;
      4:       return OP_NAND;
      5:       return OP_DOT;
      6:       return OP_TOR;
      default: return OP_FROMR;
    endcase
  endfunction

  // never fetch a byte that was never stored: turn such a fetch into a query
  task automatic put(op_t op, logic [NCELL_W-1:0] nc, logic [ICHAR_W-1:0] ic);
    instr_t c;
    c.cmd   = op;
    c.ncell = nc;
    c.ichar = ic;
    if (c.cmd == OP_CFETCH && !hlt[GEN] && ddep[GEN] > 0 &&
        !bwr[GEN][baddr_t'(dstk[GEN][ddep[GEN]-1])])
      c.cmd = OP_QUERY;
    void'(execute_op(GEN, c));
    instr_q.push_back(c);
    n_gen++;
  endtask

  task automatic put_op(op_t op);
    put(op, rnd_word(), rnd_ichar());
  endtask

  task automatic put_addr(op_t op, baddr_t lo);
    logic [NCELL_W-1:0] v;
    v = $urandom;
    v[BADDR_W-1:0] = lo;
    put(OP_LIT, v, rnd_ichar());
    put_op(op);
  endtask

  task automatic data_burst();
    while (ddep[GEN] < STACK_ENTRIES) begin
      case ($urandom_range(0, 2))
        0:       put_op(OP_LIT);
        1:       put_op(OP_QUERY);
        default: put_op((ddep[GEN] > 0) ? OP_DUP : OP_LIT);
      endcase
    end
    put_op(OP_LIT);
    put_op(OP_DUP);
    put_op(OP_QUERY);
    put_op(OP_FROMR);
    while (ddep[GEN] > 0) put_op($urandom_range(0, 1) ? OP_DOT : OP_DROP);
    put_op(OP_DROP);
    put_op(OP_ADD);
    put_op(OP_CSTORE);
  endtask

  task automatic return_burst();
    while (rdep[GEN] < STACK_ENTRIES) put_op((ddep[GEN] == 0) ? OP_LIT : OP_TOR);
    put_op(OP_LIT);
    put_op(OP_TOR);
    while (rdep[GEN] > 0) begin
      if (ddep[GEN] >= STACK_ENTRIES - 1) put_op(OP_DROP);
      else if ($urandom_range(0, 3) == 0) put_op(OP_EXIT);
      else put_op(OP_FROMR);
    end
    put_op(OP_FROMR);
    put_op(OP_EXIT);
  endtask

  task automatic gen_random(int upto);
    int     kind, n;
    baddr_t lo;
    while (n_gen < upto) begin
      kind = $urandom_range(0, 9);
      if (ddep[GEN] > 40) begin
        n = $urandom_range(10, 20);
        repeat (n) put_op($urandom_range(0, 1) ? OP_DOT : OP_DROP);
      end else if (kind < 3) begin
        n = $urandom_range(1, 6);
        repeat (n) put_op(op_t'($urandom_range(1, 15)));
      end else if (kind < 6) begin
        put_op($urandom_range(0, 1) ? OP_LIT : OP_QUERY);
        put_op($urandom_range(0, 1) ? OP_LIT : OP_QUERY);
        n = $urandom_range(3, 6);
        repeat (n) put_op(rnd_stack_op());
      end else if (kind < 8) begin
        case ($urandom_range(0, 2))
          0:       lo = baddr_t'($urandom_range(0, 63));
          1:       lo = baddr_t'(MEM_BYTES - 1 - $urandom_range(0, 63));
          default: lo = baddr_t'($urandom);
        endcase
        put(OP_LIT, $urandom, rnd_ichar());
        put_addr(OP_CSTORE, lo);
        stored_lo.push_back(lo);
        if ($urandom_range(0, 1)) begin
          put_addr(OP_CFETCH, stored_lo[$urandom_range(0, stored_lo.size() - 1)]);
          if ($urandom_range(0, 1)) put_op(OP_DOT);
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            put_op(OP_LIT);
            put_op(OP_SKIP);
          end
          1: begin
            put_op(OP_LIT);
            put_op(OP_BRANCH);
          end
          default: begin
            put_op(OP_LIT);
            put_op(OP_TOR);
            put_op(OP_EXIT);
          end
        endcase
      end
    end
  endtask

  task automatic wait_drained();
    while (instr_q.size() != 0 || s_tvalid || step_result_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_MSG)
      $display("mismatch at result %0d: %s got %h want %h", n_out, field, got, want);
  endtask

  // driver: launch the next pending instruction once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        step_result_q.push_back(execute_op(CHK, drv_instr));
        n_in <= n_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (instr_q.size() > 0) begin
          drv_instr = instr_q.pop_front();
          s_tdata  <= IN_TDATA_W'(drv_instr);
          s_tvalid <= 1'b1;
          gap_left = idle_len(drv_steady);
          if ($urandom_range(0, 49) == 0) drv_steady = !drv_steady;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: register each transfer out, then compare it with the model
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      res_fire <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_fire) begin
        n_out++;
        if (step_result_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", res_got.ptr, '0);
        end else begin
          want_res = step_result_q.pop_front();
          if (res_got.ptr !== want_res.ptr)
            report_mismatch("next_pointer", res_got.ptr, want_res.ptr);
          if (res_got.ochar !== want_res.ochar)
            report_mismatch("out_char", 32'(res_got.ochar), 32'(want_res.ochar));
          if (res_got.ovalid !== want_res.ovalid)
            report_mismatch("out_valid", 32'(res_got.ovalid), 32'(want_res.ovalid));
          if (res_got.status !== want_res.status)
            report_mismatch("status", 32'(res_got.status), 32'(want_res.status));
          if (want_res.status == ST_FAULT) n_fault++;
          if (want_res.status == ST_HALT) n_halt++;
          if (want_res.ovalid) n_emit++;
        end
      end
      res_fire <= m_tvalid && m_tready;
      res_got  <= step_res_t'(m_tdata[OUT_W-1:0]);
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = idle_len(mon_steady);
        if ($urandom_range(0, 49) == 0) mon_steady = !mon_steady;
      end
    end
  end

  // hold the receiver off once, long enough to back the block up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == LIMIT) begin
        $display("timeout after %0d cycles without a transfer", LIMIT);
        $display("tb_stack_machine_executor: errors");
        $finish;
      end
    end
  end

  initial begin
    clear_model(GEN);
    clear_model(CHK);

    put_op(OP_DROP);
    put_op(OP_EXIT);
    put(OP_LIT, 32'h7FFF_FFFF, rnd_ichar());
    put(OP_LIT, 32'h8000_0000, rnd_ichar());
    put_op(OP_ADD);
    put(OP_QUERY, rnd_word(), {ICHAR_W{1'b1}});
    put_op(OP_NAND);
    put(OP_QUERY, rnd_word(), 9'd255);
    put_op(OP_SWAP);
    put_op(OP_DUP);
    put_op(OP_DOT);
    put_op(OP_TOR);
    put_op(OP_FROMR);
    put_op(OP_TOR);
    put(OP_LIT, 32'hFFFF_FFFF, rnd_ichar());
    put_op(OP_CSTORE);
    put(OP_LIT, 32'h8000_1FFF, rnd_ichar());
    put_op(OP_CFETCH);
    put_op(OP_SKIP);
    put(OP_LIT, 32'h0, rnd_ichar());
    put_op(OP_SKIP);
    put(OP_LIT, 32'd5, rnd_ichar());
    put_op(OP_BRANCH);
    put(OP_LIT, 32'hFFFF_FFF8, rnd_ichar());
    put_op(OP_BRANCH);
    put_op(OP_EXIT);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    #1;

    data_burst();
    gen_random(280);
    wait_drained();

    return_burst();
    gen_random(540);
    put_op(OP_HALT);
    repeat (4) put_op(op_t'($urandom_range(0, 15)));
    wait_drained();
    repeat (20) @(posedge clk);

    $display("%0d instructions in, %0d results out: %0d stack faults, %0d characters",
             n_in, n_out, n_fault, n_emit);
    $display("both stacks filled past full and emptied, %0d halted steps at the end",
             n_halt);
    if (err_cnt == 0) begin
      $display("tb_stack_machine_executor: clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb_stack_machine_executor: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/sme_ctrl.sv
rtl/sme_exec.sv
rtl/stack_machine_executor.sv
tb/tb_stack_machine_executor.sv
